### rtl/delimited_token_splitter_assert.svh
// assertion macros for the delimited token splitter
`ifndef DELIMITED_TOKEN_SPLITTER_ASSERT_SVH
`define DELIMITED_TOKEN_SPLITTER_ASSERT_SVH

// same-cycle implication, checked on every rising clock edge out of reset
`define DTS_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("dts check failed");

// next-cycle implication
`define DTS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("dts check failed");

`endif

### rtl/dts_pkg.sv
// shared types and constants of the delimited token splitter
package dts_pkg;

	localparam int CharW   = 8;
	localparam int TypeW   = 4;
	localparam int PairW   = 21;
	localparam int DataW   = 21;
	localparam int IndexW  = 3;
	localparam int PairRegs = 4;
	localparam int QDepth  = 4;

	localparam logic [CharW-1:0] SPACE_CH = 8'h20;
	localparam logic [CharW-1:0] LINE_END = 8'h00;

	typedef logic [IndexW-1:0] cfg_idx_t;

	localparam cfg_idx_t IDX_WORD_TYPE = cfg_idx_t'(PairRegs);

	typedef enum logic [1:0] {
		KIND_CHAR      = 2'd0,
		KIND_TOKEN_END = 2'd1,
		KIND_LINE_END  = 2'd2
	} kind_t;

	typedef struct packed {
		logic             en;
		logic [TypeW-1:0] ttype;
		logic [CharW-1:0] close_ch;
		logic [CharW-1:0] open_ch;
	} pair_t;

	typedef struct packed {
		logic             hit;
		logic [CharW-1:0] close_ch;
		logic [TypeW-1:0] ttype;
		logic [TypeW-1:0] word_type;
	} match_t;

	typedef struct packed {
		kind_t            kind;
		logic [CharW-1:0] out_char;
		logic [TypeW-1:0] token_type;
		logic             unclosed;
	} res_t;

	typedef struct packed {
		logic [1:0] n;
		res_t       r0;
		res_t       r1;
	} push_t;

endpackage

### rtl/dts_in_if.sv
// character input channel
interface dts_in_if;
	logic                      valid;
	logic                      ready;
	logic [dts_pkg::CharW-1:0] ch;

	modport source (output valid, output ch, input ready);
	modport sink (input valid, input ch, output ready);
endinterface

### rtl/dts_out_if.sv
// token result output channel
interface dts_out_if;
	logic                      valid;
	logic                      ready;
	logic [1:0]                kind;
	logic [dts_pkg::CharW-1:0] out_char;
	logic [dts_pkg::TypeW-1:0] token_type;
	logic                      unclosed;

	modport source (output valid, output kind, output out_char, output token_type,
		output unclosed, input ready);
	modport sink (input valid, input kind, input out_char, input token_type,
		input unclosed, output ready);
endinterface

### rtl/dts_cfg.sv
// delimiter pair registers and priority match of the opening character
module dts_cfg #(
	parameter int PAIRS = 4
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       wr_en,
	input  dts_pkg::cfg_idx_t          wr_index,
	input  logic [dts_pkg::DataW-1:0]  wr_data,
	input  logic [dts_pkg::CharW-1:0]  ch,
	output dts_pkg::match_t            match
);

	localparam int NReg = (PAIRS < dts_pkg::PairRegs) ? PAIRS : dts_pkg::PairRegs;

	dts_pkg::pair_t                pair_q [NReg];
	logic [dts_pkg::TypeW-1:0]     word_type_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NReg; i++) begin
				pair_q[i] <= '0;
			end
			word_type_q <= '0;
		end else if (wr_en) begin
			for (int i = 0; i < NReg; i++) begin
				if (wr_index == dts_pkg::cfg_idx_t'(i)) begin
					pair_q[i] <= dts_pkg::pair_t'(wr_data[dts_pkg::PairW-1:0]);
				end
			end
			if (wr_index == dts_pkg::IDX_WORD_TYPE) begin
				word_type_q <= wr_data[dts_pkg::TypeW-1:0];
			end
		end
	end

	// lowest numbered enabled pair wins
	always_comb begin
		match           = '0;
		match.word_type = word_type_q;
		for (int i = NReg - 1; i >= 0; i--) begin
			if (pair_q[i].en && (pair_q[i].open_ch == ch)) begin
				match.hit      = 1'b1;
				match.close_ch = pair_q[i].close_ch;
				match.ttype    = pair_q[i].ttype;
			end
		end
	end

endmodule

### rtl/dts_step.sv
// tokenizer mode state and per-character result decision
module dts_step (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      fire,
	input  logic [dts_pkg::CharW-1:0] ch,
	input  dts_pkg::match_t           match,
	output dts_pkg::push_t            push
);

	typedef enum logic [1:0] {
		MODE_GAP   = 2'd0,
		MODE_WORD  = 2'd1,
		MODE_QUOTE = 2'd2
	} mode_t;

	mode_t                     mode_q, mode_d;
	logic [dts_pkg::CharW-1:0] close_q, close_d;
	logic [dts_pkg::TypeW-1:0] type_q, type_d;
	dts_pkg::push_t            push_d;

	always_comb begin
		mode_d  = mode_q;
		close_d = close_q;
		type_d  = type_q;
		push_d  = '0;
		case (mode_q)
			MODE_WORD: begin
				if (ch == dts_pkg::LINE_END) begin
					push_d.n                = 2'd2;
					push_d.r0.kind          = dts_pkg::KIND_TOKEN_END;
					push_d.r0.token_type    = type_q;
					push_d.r1.kind          = dts_pkg::KIND_LINE_END;
					mode_d                  = MODE_GAP;
				end else if (ch == dts_pkg::SPACE_CH) begin
					push_d.n                = 2'd1;
					push_d.r0.kind          = dts_pkg::KIND_TOKEN_END;
					push_d.r0.token_type    = type_q;
					mode_d                  = MODE_GAP;
				end else begin
					push_d.n                = 2'd1;
					push_d.r0.kind          = dts_pkg::KIND_CHAR;
					push_d.r0.out_char      = ch;
					push_d.r0.token_type    = type_q;
				end
			end
			MODE_QUOTE: begin
				if (ch == dts_pkg::LINE_END) begin
					push_d.n                = 2'd2;
					push_d.r0.kind          = dts_pkg::KIND_TOKEN_END;
					push_d.r0.token_type    = type_q;
					push_d.r0.unclosed      = 1'b1;
					push_d.r1.kind          = dts_pkg::KIND_LINE_END;
					mode_d                  = MODE_GAP;
				end else if (ch == close_q) begin
					push_d.n                = 2'd1;
					push_d.r0.kind          = dts_pkg::KIND_TOKEN_END;
					push_d.r0.token_type    = type_q;
					mode_d                  = MODE_GAP;
				end else begin
					push_d.n                = 2'd1;
					push_d.r0.kind          = dts_pkg::KIND_CHAR;
					push_d.r0.out_char      = ch;
					push_d.r0.token_type    = type_q;
				end
			end
			default: begin
				mode_d = MODE_GAP;
				if (ch == dts_pkg::LINE_END) begin
					push_d.n                = 2'd1;
					push_d.r0.kind          = dts_pkg::KIND_LINE_END;
				end else if (ch == dts_pkg::SPACE_CH) begin
					push_d.n                = 2'd0;
				end else if (match.hit) begin
					mode_d                  = MODE_QUOTE;
					close_d                 = match.close_ch;
					type_d                  = match.ttype;
				end else begin
					mode_d                  = MODE_WORD;
					type_d                  = match.word_type;
					push_d.n                = 2'd1;
					push_d.r0.kind          = dts_pkg::KIND_CHAR;
					push_d.r0.out_char      = ch;
					push_d.r0.token_type    = match.word_type;
				end
			end
		endcase
	end

	always_comb begin
		push = push_d;
		if (!fire) begin
			push.n = 2'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_GAP;
			close_q <= '0;
			type_q  <= '0;
		end else if (fire) begin
			mode_q  <= mode_d;
			close_q <= close_d;
			type_q  <= type_d;
		end
	end

endmodule

### rtl/dts_res_fifo.sv
// result queue taking up to two results per cycle and giving one per cycle while the output is ready
module dts_res_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  dts_pkg::push_t push,
	output logic           room,
	output logic [$clog2(dts_pkg::QDepth):0] level,
	output logic           valid,
	input  logic           ready,
	output dts_pkg::res_t  head
);

	localparam int PtrW = $clog2(dts_pkg::QDepth);

	typedef logic [PtrW-1:0] ptr_t;
	typedef logic [PtrW:0]   cnt_t;

	dts_pkg::res_t ent_q [dts_pkg::QDepth];
	ptr_t          rd_q, wr_q;
	cnt_t          cnt_q;
	logic          pop;

	assign valid = (cnt_q != '0);
	assign pop   = valid && ready;
	assign room  = (cnt_q <= cnt_t'(dts_pkg::QDepth - 2));
	assign level = cnt_q;
	assign head  = ent_q[rd_q];

	always_ff @(posedge clk) begin
		if (push.n != 2'd0) begin
			ent_q[wr_q] <= push.r0;
		end
		if (push.n == 2'd2) begin
			ent_q[wr_q + ptr_t'(1)] <= push.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q  <= '0;
			wr_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + ptr_t'(push.n);
			if (pop) begin
				rd_q <= rd_q + ptr_t'(1);
			end
			cnt_q <= cnt_q + cnt_t'(push.n) - cnt_t'(pop);
		end
	end

endmodule

### rtl/delimited_token_splitter.sv
// Splits a 0-terminated character stream into tokens: spaces are skipped between
// tokens, an enabled pair's opening character starts a quoted token that runs to
// its closing character, anything else starts a word that runs to a space. One
// character is taken per cycle, every cycle, as long as the four-entry result
// queue has room for two results; results leave one per cycle while the output
// is ready, so the sustained rate is one character per cycle, limited by the
// single-result output port when a token ends at the line end (two results for
// that character). Characters pass the input register, then the result queue.
// Configuration must be written only while the block is empty (not enforced).
`include "delimited_token_splitter_assert.svh"

module delimited_token_splitter #(
	parameter int PAIRS = 4
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr_en,
	input  dts_pkg::cfg_idx_t             wr_index,
	input  logic [dts_pkg::DataW-1:0]     wr_data,
	dts_in_if.sink                        chars,
	dts_out_if.source                     tokens
);

	logic                                 valid_s1;
	logic [dts_pkg::CharW-1:0]            ch_s1;
	logic                                 room;
	logic                                 fire;
	logic [$clog2(dts_pkg::QDepth):0]     level;
	dts_pkg::match_t                      match;
	dts_pkg::push_t                       push;
	dts_pkg::res_t                        head;

	assign chars.ready = !valid_s1 || room;
	assign fire        = valid_s1 && room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (chars.ready) begin
			valid_s1 <= chars.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (chars.valid && chars.ready) begin
			ch_s1 <= chars.ch;
		end
	end

	dts_cfg #(
		.PAIRS(PAIRS)
	) u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr_en),
		.wr_index(wr_index),
		.wr_data (wr_data),
		.ch      (ch_s1),
		.match   (match)
	);

	dts_step u_step (
		.clk   (clk),
		.arst_n(arst_n),
		.fire  (fire),
		.ch    (ch_s1),
		.match (match),
		.push  (push)
	);

	dts_res_fifo u_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.room  (room),
		.level (level),
		.valid (tokens.valid),
		.ready (tokens.ready),
		.head  (head)
	);

	assign tokens.kind       = head.kind;
	assign tokens.out_char   = head.out_char;
	assign tokens.token_type = head.token_type;
	assign tokens.unclosed   = head.unclosed;

	`DTS_ASSERT_SAME(a_no_overflow, 1'b1, level <= ($clog2(dts_pkg::QDepth)+1)'(dts_pkg::QDepth))
	`DTS_ASSERT_SAME(a_pair_ends_line, push.n == 2'd2, push.r1.kind == dts_pkg::KIND_LINE_END && push.r0.kind == dts_pkg::KIND_TOKEN_END)
	`DTS_ASSERT_NEXT(a_stall_holds, valid_s1 && !room, valid_s1 && $stable(ch_s1))
	`DTS_ASSERT_SAME(a_line_end_clean, tokens.valid && tokens.kind == dts_pkg::KIND_LINE_END, tokens.out_char == '0 && tokens.token_type == '0 && !tokens.unclosed)

endmodule
